@@ rtl/kmr_pkg.sv @@
// Shared types and constants for the key macro recorder and player.
`timescale 1ns / 1ps

package kmr_pkg;

    // Default sizing: steps per slot and number of slots
    localparam int STEPS_DEF = 128;
    localparam int SLOTS_DEF = 3;

    // Key code width and stored step width (press flag above the code)
    localparam int CODE_W = 32;
    localparam int STEP_W = CODE_W + 1;

    // Command codes
    typedef enum logic [2:0] {
        OP_KEY    = 3'd0,
        OP_TOGGLE = 3'd1,
        OP_PLAY   = 3'd2,
        OP_TICK   = 3'd3,
        OP_SLEEP  = 3'd4
    } op_t;

    // Notice codes reported with each result item
    typedef enum logic [2:0] {
        NOTE_NONE       = 3'd0,
        NOTE_REC_START  = 3'd1,
        NOTE_REC_STOP   = 3'd2,
        NOTE_PLAY_START = 3'd3,
        NOTE_FULL       = 3'd4,
        NOTE_PLAY_DONE  = 3'd5
    } notice_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_I,
        ST_SCAN_IW,
        ST_SCAN_J,
        ST_SCAN_JW,
        ST_PLAY_W,
        ST_EMIT
    } kmr_state_t;

endpackage

@@ rtl/kmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kmr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 384
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/key_macro_record_playback.sv @@
// Top level of the key macro recorder and player: sequencer, slot counts and step memory.
`timescale 1ns / 1ps

// Usage
//   Command channel (cmd_valid / cmd_stall): opcode, slot, key_code, key_pressed.
//   Result channel (rsp_valid / rsp_stall): exactly one result item per command.
//   A command is taken only while the sequencer is idle; cmd_stall is high otherwise.
//   Path from accept to rsp_valid: execute state, emit state and output register for key,
//   toggle, play and sleep; a tick that replays a step adds a wait state for one memory read.
//   Stopping a recording runs the release scan on the step memory through one
//   shared compare: each step is read in the outer scan states, and each pressed
//   step then walks the later steps in the inner scan states. A new command is
//   taken only once the sequencer has emitted the last result and returned to idle.
//   The finished result sits in an output register; while rsp_stall is high the
//   result holds and a newer result waits in the emit state; the next command may
//   already be waiting on the input.
//   Reset (rst_n low, asynchronous) empties every slot count, stops recording and
//   playback and drops any pending result. Step memory is not cleared: only steps
//   below a slot's count are ever read.
module key_macro_record_playback
    import kmr_pkg::*;
#(
    parameter int STEPS = STEPS_DEF,
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic [2:0]        opcode,
    input  logic [1:0]        slot,
    input  logic [CODE_W-1:0] key_code,
    input  logic              key_pressed,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic              key_valid,
    output logic [CODE_W-1:0] out_key_code,
    output logic              out_key_pressed,
    output logic [1:0]        recording_now,
    output logic [1:0]        playing_now,
    output logic [2:0]        notice
);

    localparam int CW    = $clog2(STEPS + 1);
    localparam int IW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH = SLOTS * STEPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] STEPS_C = CW'(STEPS);
    localparam logic [AW-1:0] STEPS_A = AW'(STEPS);

    // Control state
    kmr_state_t  state_reg, state_next;
    logic [1:0]  rec_reg, rec_next;
    logic [1:0]  play_reg, play_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic [CW-1:0] cnt_reg [SLOTS];
    logic [CW-1:0] cnt_next [SLOTS];
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic        ov_reg, ov_next;

    // Captured command and result staging
    logic [2:0]        op_reg, op_next;
    logic [1:0]        sl_reg, sl_next;
    logic [1:0]        wslot_reg, wslot_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              pr_reg, pr_next;
    logic [CODE_W-1:0] scode_reg, scode_next;
    notice_t           note_reg, note_next;
    logic              kv_reg, kv_next;
    logic [CODE_W-1:0] kc_reg, kc_next;
    logic              kp_reg, kp_next;

    // Output register payload
    logic              o_kv_reg;
    logic [CODE_W-1:0] o_kc_reg;
    logic              o_kp_reg;
    logic [1:0]        o_rec_reg;
    logic [1:0]        o_play_reg;
    notice_t           o_note_reg;

    // Memory port
    logic              mem_we;
    logic              mem_re;
    logic [CW-1:0]     mem_idx;
    logic [AW-1:0]     mem_addr;
    logic [STEP_W-1:0] mem_wdata;
    logic [STEP_W-1:0] mem_rdata;

    // Decode helpers
    logic [1:0]    tgt_slot;
    logic [2:0]    wsm1;
    logic [SIW-1:0] widx;
    logic          wslot_ok;
    logic          sl_ok;
    logic          play_ok;
    logic [CW-1:0] cnt_cur;
    logic [CW-1:0] cnt_inc;
    logic          room;
    logic          key_fill;
    logic          key_full;
    logic          tog_ok;
    logic          go_scan;
    logic          go_play;
    logic          i_lt;
    logic          j_lt;
    logic          rd_match;
    logic          out_free;
    logic          emit_fire;

    // Target slot: recording slot for keys and play while recording; playing slot for ticks
    assign tgt_slot = (opcode == OP_KEY) ? rec_reg :
                      (opcode == OP_TICK) ? play_reg :
                      ((opcode == OP_PLAY) && (rec_reg != 2'd0)) ? rec_reg : slot;

    assign wsm1     = 3'(wslot_reg) - 3'd1;
    assign widx     = wsm1[SIW-1:0];
    assign wslot_ok = (wslot_reg != 2'd0) && (int'(wslot_reg) <= SLOTS);
    assign sl_ok    = (sl_reg != 2'd0) && (int'(sl_reg) <= SLOTS);
    assign play_ok  = (play_reg != 2'd0) && (int'(play_reg) <= SLOTS);
    assign cnt_cur  = wslot_ok ? cnt_reg[widx] : '0;
    assign cnt_inc  = CW'(cnt_cur + 1'b1);
    assign room     = cnt_cur < STEPS_C;

    // Per-command decisions in the execute state
    assign key_fill = (rec_reg != 2'd0) && (play_reg == 2'd0) && wslot_ok && room;
    assign key_full = key_fill && (cnt_inc == STEPS_C);
    assign tog_ok   = sl_ok && (play_reg == 2'd0);
    assign go_scan  = ((op_reg == OP_KEY) && key_full) ||
                      ((op_reg == OP_TOGGLE) && tog_ok && (rec_reg == sl_reg)) ||
                      ((op_reg == OP_PLAY) && sl_ok && (rec_reg != 2'd0) &&
                       (play_reg == 2'd0));
    assign go_play  = (op_reg == OP_TICK) && play_ok && (pidx_reg < cnt_cur);

    // Shared compare for the release scan
    assign i_lt     = i_reg < cnt_cur;
    assign j_lt     = j_reg < cnt_cur;
    assign rd_match = (mem_rdata[CODE_W-1:0] == scode_reg) && !mem_rdata[CODE_W];

    assign out_free  = !ov_reg || !rsp_stall;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go_scan)
                begin
                    state_next = ST_SCAN_I;
                end
                else if (go_play)
                begin
                    state_next = ST_PLAY_W;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN_I:
            begin
                state_next = i_lt ? ST_SCAN_IW : ST_EMIT;
            end
            ST_SCAN_IW:
            begin
                state_next = mem_rdata[CODE_W] ? ST_SCAN_J : ST_SCAN_I;
            end
            ST_SCAN_J:
            begin
                state_next = j_lt ? ST_SCAN_JW : ST_SCAN_I;
            end
            ST_SCAN_JW:
            begin
                state_next = rd_match ? ST_SCAN_I : ST_SCAN_J;
            end
            ST_PLAY_W:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control per state
    always_comb
    begin
        rec_next   = rec_reg;
        play_next  = play_reg;
        pidx_next  = pidx_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        op_next    = op_reg;
        sl_next    = sl_reg;
        wslot_next = wslot_reg;
        code_next  = code_reg;
        pr_next    = pr_reg;
        scode_next = scode_reg;
        note_next  = note_reg;
        kv_next    = kv_reg;
        kc_next    = kc_reg;
        kp_next    = kp_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_idx    = '0;
        mem_wdata  = {pr_reg, code_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = opcode;
                    sl_next    = slot;
                    code_next  = key_code;
                    pr_next    = key_pressed;
                    wslot_next = tgt_slot;
                    note_next  = NOTE_NONE;
                    kv_next    = 1'b0;
                    kc_next    = '0;
                    kp_next    = 1'b0;
                    i_next     = '0;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_KEY:
                    begin
                        // append the key event; a full slot stops with a scan
                        if (key_fill)
                        begin
                            mem_we         = 1'b1;
                            mem_idx        = cnt_cur;
                            cnt_next[widx] = cnt_inc;
                            if (key_full)
                            begin
                                note_next = NOTE_FULL;
                            end
                        end
                    end
                    OP_TOGGLE:
                    begin
                        if (tog_ok)
                        begin
                            if (rec_reg == sl_reg)
                            begin
                                note_next = NOTE_REC_STOP;
                            end
                            else
                            begin
                                // new recording drops the old one as it stands
                                cnt_next[widx] = '0;
                                rec_next       = sl_reg;
                                note_next      = NOTE_REC_START;
                            end
                        end
                    end
                    OP_PLAY:
                    begin
                        if (sl_ok)
                        begin
                            if (rec_reg != 2'd0)
                            begin
                                if (play_reg == 2'd0)
                                begin
                                    note_next = NOTE_REC_STOP;
                                end
                            end
                            else if ((play_reg == 2'd0) && (cnt_cur != '0))
                            begin
                                play_next = sl_reg;
                                pidx_next = '0;
                                note_next = NOTE_PLAY_START;
                            end
                        end
                    end
                    OP_TICK:
                    begin
                        if (play_reg != 2'd0)
                        begin
                            if (!play_ok)
                            begin
                                play_next = 2'd0;
                            end
                            else if (pidx_reg < cnt_cur)
                            begin
                                mem_re  = 1'b1;
                                mem_idx = pidx_reg;
                            end
                            else
                            begin
                                play_next = 2'd0;
                                pidx_next = '0;
                                note_next = NOTE_PLAY_DONE;
                            end
                        end
                    end
                    OP_SLEEP:
                    begin
                        play_next = 2'd0;
                        pidx_next = '0;
                        rec_next  = 2'd0;
                    end
                    default:
                    begin
                        note_next = NOTE_NONE;
                    end
                endcase
            end
            ST_SCAN_I:
            begin
                // outer walk; past the end the recording is closed
                if (i_lt)
                begin
                    mem_re  = 1'b1;
                    mem_idx = i_reg;
                end
                else
                begin
                    rec_next = 2'd0;
                end
            end
            ST_SCAN_IW:
            begin
                if (mem_rdata[CODE_W])
                begin
                    scode_next = mem_rdata[CODE_W-1:0];
                    j_next     = CW'(i_reg + 1'b1);
                end
                else
                begin
                    i_next = CW'(i_reg + 1'b1);
                end
            end
            ST_SCAN_J:
            begin
                // inner walk; no later release found means append one
                if (j_lt)
                begin
                    mem_re  = 1'b1;
                    mem_idx = j_reg;
                end
                else
                begin
                    if (room)
                    begin
                        mem_we         = 1'b1;
                        mem_idx        = cnt_cur;
                        mem_wdata      = {1'b0, scode_reg};
                        cnt_next[widx] = cnt_inc;
                    end
                    i_next = CW'(i_reg + 1'b1);
                end
            end
            ST_SCAN_JW:
            begin
                if (rd_match)
                begin
                    i_next = CW'(i_reg + 1'b1);
                end
                else
                begin
                    j_next = CW'(j_reg + 1'b1);
                end
            end
            ST_PLAY_W:
            begin
                kv_next   = 1'b1;
                kc_next   = mem_rdata[CODE_W-1:0];
                kp_next   = mem_rdata[CODE_W];
                pidx_next = CW'(pidx_reg + 1'b1);
            end
            ST_EMIT:
            begin
                note_next = note_reg;
            end
            default:
            begin
                note_next = note_reg;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        if (emit_fire)
        begin
            ov_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    // Memory address: slot base plus step index
    assign mem_addr = AW'(AW'(widx) * STEPS_A) + AW'(mem_idx[IW-1:0]);

    kmr_ram #(
        .WIDTH (STEP_W),
        .DEPTH (DEPTH)
    ) u_step_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rec_reg   <= 2'd0;
            play_reg  <= 2'd0;
            pidx_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            ov_reg    <= 1'b0;
            wslot_reg <= 2'd0;
            for (int k = 0; k < SLOTS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rec_reg   <= rec_next;
            play_reg  <= play_next;
            pidx_reg  <= pidx_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ov_reg    <= ov_next;
            wslot_reg <= wslot_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        sl_reg    <= sl_next;
        code_reg  <= code_next;
        pr_reg    <= pr_next;
        scode_reg <= scode_next;
        note_reg  <= note_next;
        kv_reg    <= kv_next;
        kc_reg    <= kc_next;
        kp_reg    <= kp_next;
        if (emit_fire)
        begin
            o_kv_reg   <= kv_reg;
            o_kc_reg   <= kc_reg;
            o_kp_reg   <= kp_reg;
            o_rec_reg  <= rec_reg;
            o_play_reg <= play_reg;
            o_note_reg <= note_reg;
        end
    end

    assign cmd_stall       = (state_reg != ST_IDLE);
    assign rsp_valid       = ov_reg;
    assign key_valid       = o_kv_reg;
    assign out_key_code    = o_kc_reg;
    assign out_key_pressed = o_kp_reg;
    assign recording_now   = o_rec_reg;
    assign playing_now     = o_play_reg;
    assign notice          = o_note_reg;

    // Recording and playback never run together
    assert property (@(posedge clk) disable iff (!rst_n)
        !((rec_reg != 2'd0) && (play_reg != 2'd0)))
        else $error("recording and playback active together");

    // A replayed step is only reported while its slot still plays
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && key_valid) |-> (playing_now != 2'd0))
        else $error("replayed step without an active playback");

    // A full slot always closes its recording
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (notice == NOTE_FULL)) |-> (recording_now == 2'd0))
        else $error("full notice while still recording");

    // Slot count never passes the slot size
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_cur <= STEPS_C)
        else $error("slot count beyond slot size");

endmodule
